[src/stuffed_frame_deserializer_core_macros.svh]
// assertion helpers shared by the deserializer modules
// each expects clk and rst_n to be visible in the module that uses it
`ifndef STUFFED_FRAME_DESERIALIZER_CORE_MACROS_SVH
`define STUFFED_FRAME_DESERIALIZER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfd assertion failed");

// next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfd assertion failed");

`endif

[src/sfd_pkg.sv]
`default_nettype none

package sfd_pkg;

  // line coding
  localparam logic [7:0] START_BYTE  = 8'h55;
  localparam logic [7:0] ESCAPE_BYTE = 8'hAA;
  localparam logic [7:0] ESC_CODE_55 = 8'h05;
  localparam logic [7:0] ESC_CODE_AA = 8'h0A;

  // crc-8, msb first
  localparam logic [7:0] CRC_PRESET = 8'hFF;
  localparam logic [7:0] CRC_POLY   = 8'h1D;

  // result kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD_CRC = 2'd2;

  // decoded byte queue between front and back
  localparam int SFD_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } sfd_result_t;

  // one byte through the crc register, eight shift steps
  function automatic logic [7:0] sfd_crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/sfd_if.sv]
`default_nettype none

// raw line byte channel
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// decoded result channel
interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

[src/sfd_front.sv]
`default_nettype none

module sfd_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_ready,
  output logic            push_valid,
  output logic [7:0]      push_byte,
  input  wire logic       push_ready
);
  import sfd_pkg::*;

  logic esc_pending_r;
  logic esc_pending_nxt;
  logic is_escape;
  logic in_take;

  // a bare escape byte is swallowed here and never queued
  assign is_escape  = !esc_pending_r && (in_rx_byte == ESCAPE_BYTE);
  assign in_ready   = push_ready;
  assign in_take    = in_valid && in_ready;
  assign push_valid = in_valid && !is_escape;

  // unstuff the byte after an escape
  always_comb begin
    push_byte = in_rx_byte;
    if (esc_pending_r) begin
      if (in_rx_byte == ESC_CODE_55) begin
        push_byte = START_BYTE;
      end else if (in_rx_byte == ESC_CODE_AA) begin
        push_byte = ESCAPE_BYTE;
      end
    end
  end

  // escape flag follows each transfer
  always_comb begin
    esc_pending_nxt = esc_pending_r;
    if (in_take) begin
      esc_pending_nxt = is_escape;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pending_r <= 1'b0;
    end else begin
      esc_pending_r <= esc_pending_nxt;
    end
  end

endmodule

`default_nettype wire

[src/sfd_queue.sv]
`default_nettype none
`include "stuffed_frame_deserializer_core_macros.svh"

module sfd_queue #(
  parameter int DEPTH = sfd_pkg::SFD_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  input  wire logic [7:0] push_byte,
  output logic            push_ready,
  output logic            pop_valid,
  output logic [7:0]      pop_byte,
  input  wire logic       pop_ready
);
  import sfd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [7:0]       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_byte   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_byte;
    end
  end

  `SFD_ASSERT_NOW(a_count_bounded, 1'b1, count_r <= FULL_CNT)
  `SFD_ASSERT_NEXT(a_pop_drains, pop && !push, count_r == $past(count_r) - 1'b1)

endmodule

`default_nettype wire

[src/sfd_back.sv]
`default_nettype none
`include "stuffed_frame_deserializer_core_macros.svh"

module sfd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire logic [7:0]       q_byte,
  output logic                  q_ready,
  output logic                  out_valid,
  output sfd_pkg::sfd_result_t  out_res,
  input  wire logic             out_ready
);
  import sfd_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_CRC     = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  sfd_result_t res_r, res_nxt;
  logic        q_pop;
  logic [7:0]  cnt_inc;
  logic [7:0]  crc_upd;

  // output register frees up when empty or being drained
  assign q_ready   = !out_valid_r || out_ready;
  assign q_pop     = q_valid && q_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign cnt_inc   = byte_count_r + 8'd1;
  assign crc_upd   = sfd_crc8_update(crc_r, q_byte);

  // frame state machine, one decoded byte per transfer
  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt   = byte_count_r;
    crc_nxt          = crc_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    if (q_pop) begin
      out_valid_nxt = 1'b0;
      case (phase_r)
        PH_HUNT: begin
          if (q_byte == START_BYTE) begin
            phase_nxt      = PH_LENGTH;
            byte_count_nxt = 8'd0;
            crc_nxt        = CRC_PRESET;
          end
        end
        PH_LENGTH: begin
          frame_length_nxt = q_byte;
          crc_nxt          = crc_upd;
          phase_nxt        = (q_byte != 8'd0) ? PH_PAYLOAD : PH_CRC;
        end
        PH_PAYLOAD: begin
          crc_nxt           = crc_upd;
          byte_count_nxt    = cnt_inc;
          if (cnt_inc >= frame_length_r) begin
            phase_nxt = PH_CRC;
          end
          out_valid_nxt     = 1'b1;
          res_nxt.kind      = KIND_DATA;
          res_nxt.data_byte = q_byte;
        end
        PH_CRC: begin
          out_valid_nxt     = 1'b1;
          res_nxt.kind      = (crc_r == q_byte) ? KIND_GOOD : KIND_BAD_CRC;
          res_nxt.data_byte = q_byte;
          phase_nxt         = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      frame_length_r <= 8'd0;
      byte_count_r   <= 8'd0;
      crc_r          <= CRC_PRESET;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      crc_r          <= crc_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  `SFD_ASSERT_NEXT(a_crc_ends_frame, q_pop && phase_r == PH_CRC,
                   out_valid_r && res_r.kind != KIND_DATA && phase_r == PH_HUNT)
  `SFD_ASSERT_NEXT(a_crc_idle_hold, !q_pop, $stable(crc_r) && $stable(phase_r))
  `SFD_ASSERT_NOW(a_kind_legal, out_valid_r,
                  res_r.kind == KIND_DATA || res_r.kind == KIND_GOOD || res_r.kind == KIND_BAD_CRC)

endmodule

`default_nettype wire

[src/stuffed_frame_deserializer_core.sv]
// Byte-stuffed frame receiver with CRC-8 check.
// in_ch carries one raw line byte per transfer (rx_byte). 0xAA escapes the
// next byte (0x05 -> 0x55, 0x0A -> 0xAA); decoded 0x55 opens a frame, then
// come a length byte, that many payload bytes and a CRC-8 byte (poly 0x1D,
// preset 0xFF per frame, over length and payload).
// out_ch carries one result per payload byte (kind 0, decoded byte) and one
// per CRC byte (kind 1 good or kind 2 bad, with the received CRC byte).
// Escapes, hunt bytes and the length byte give no result.
// Throughput: one raw byte per cycle while out_ch is not stalled, set by the
// FSM and CRC update in the back end. A transferred byte passes the queue
// register, then the result register, before it can leave out_ch.
// A stalled out_ch fills the decoded byte queue (QUEUE_DEPTH entries), after
// which in_ch.ready drops; a waiting result holds steady until taken.
// Reset (rst_n low, synchronous) clears the queue and returns to hunting
// with no escape pending and no result pending.
`default_nettype none

module stuffed_frame_deserializer_core #(
  parameter int QUEUE_DEPTH = sfd_pkg::SFD_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch
);
  import sfd_pkg::*;

  logic        f_push_valid;
  logic [7:0]  f_push_byte;
  logic        f_push_ready;
  logic        q_valid;
  logic [7:0]  q_byte;
  logic        q_ready;
  sfd_result_t res;

  // unstuffing front end
  sfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_rx_byte (in_ch.rx_byte),
    .in_ready   (in_ch.ready),
    .push_valid (f_push_valid),
    .push_byte  (f_push_byte),
    .push_ready (f_push_ready)
  );

  // decoded byte queue
  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_push_valid),
    .push_byte  (f_push_byte),
    .push_ready (f_push_ready),
    .pop_valid  (q_valid),
    .pop_byte   (q_byte),
    .pop_ready  (q_ready)
  );

  // framing and crc back end
  sfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_byte    (q_byte),
    .q_ready   (q_ready),
    .out_valid (out_ch.valid),
    .out_res   (res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.kind      = res.kind;
  assign out_ch.data_byte = res.data_byte;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
  import sfd_pkg::*;

  localparam int RANDOM_LINE_BYTES = 1650;
  localparam int IDLE_LIMIT        = 2000;
  localparam int HOLD_OFF_CYCLES   = 300;
  localparam int DRAIN_CYCLES      = 12;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [1:0] {HUNT, GET_LENGTH, GET_PAYLOAD, GET_CRC} rx_phase_t;

  // tracks the frame decoder state and holds the results it should produce
  class deframer_model;
    rx_phase_t   phase;
    bit          esc_pending;
    logic [7:0]  frame_len;
    logic [7:0]  payload_seen;
    logic [7:0]  crc;
    sfd_result_t expected_results[$];
    int          mismatches;

    function new();
      phase        = HUNT;
      esc_pending  = 1'b0;
      frame_len    = '0;
      payload_seen = '0;
      crc          = CRC_PRESET;
      mismatches   = 0;
    endfunction

    // crc-8 msb first, one input bit per shift
    static function logic [7:0] crc_step(logic [7:0] crc_in, logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc_in;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    // one accepted line byte: unstuff, then advance the frame machine
    function void take_line_byte(logic [7:0] raw);
      logic [7:0]  b;
      sfd_result_t r;
      b = raw;
      if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == ESC_CODE_55) b = START_BYTE;
        else if (b == ESC_CODE_AA) b = ESCAPE_BYTE;
      end else if (b == ESCAPE_BYTE) begin
        esc_pending = 1'b1;
        return;
      end
      case (phase)
        HUNT: begin
          if (b == START_BYTE) begin
            phase        = GET_LENGTH;
            payload_seen = '0;
            crc          = CRC_PRESET;
          end
        end
        GET_LENGTH: begin
          frame_len = b;
          crc       = crc_step(crc, b);
          phase     = (b != 8'd0) ? GET_PAYLOAD : GET_CRC;
        end
        GET_PAYLOAD: begin
          crc          = crc_step(crc, b);
          payload_seen = payload_seen + 8'd1;
          if (payload_seen >= frame_len) phase = GET_CRC;
          r.kind      = KIND_DATA;
          r.data_byte = b;
          expected_results.push_back(r);
        end
        default: begin
          r.kind      = (crc == b) ? KIND_GOOD : KIND_BAD_CRC;
          r.data_byte = b;
          expected_results.push_back(r);
          phase = HUNT;
        end
      endcase
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic [1:0] kind, logic [7:0] data_byte);
      sfd_result_t exp_r;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind=%0d data_byte=%02h", kind, data_byte);
        mismatches++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (kind !== exp_r.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", exp_r.kind, kind);
        mismatches++;
      end
      if (data_byte !== exp_r.data_byte) begin
        $error("data_byte mismatch: expected %02h, actual %02h", exp_r.data_byte, data_byte);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sfd_in_if  in_if();
  sfd_out_if out_if();

  stuffed_frame_deserializer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  deframer_model model = new();
  byte_q_t       line_bytes;
  int            bytes_taken = 0;
  int            idle_cycles = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stuff one decoded byte onto the line, picking among legal encodings
  function void put_decoded(logic [7:0] d);
    if (d == ESCAPE_BYTE) begin
      line_bytes.push_back(ESCAPE_BYTE);
      // escape after escape also decodes to the escape value
      line_bytes.push_back(($urandom_range(0, 1) == 0) ? ESC_CODE_AA : ESCAPE_BYTE);
    end else if (d == START_BYTE) begin
      if ($urandom_range(0, 1) == 0) line_bytes.push_back(START_BYTE);
      else begin
        line_bytes.push_back(ESCAPE_BYTE);
        line_bytes.push_back(ESC_CODE_55);
      end
    end else if (d == ESC_CODE_55 || d == ESC_CODE_AA) begin
      line_bytes.push_back(d);
    end else begin
      // unknown escaped byte passes through unchanged
      if ($urandom_range(0, 7) == 0) line_bytes.push_back(ESCAPE_BYTE);
      line_bytes.push_back(d);
    end
  endfunction

  function logic [7:0] pick_payload();
    logic [7:0] specials[6];
    specials = '{START_BYTE, ESCAPE_BYTE, ESC_CODE_55, ESC_CODE_AA, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  // one random frame, sometimes cut short or with a bad crc
  function void add_random_frame(bit longest);
    logic [7:0] len;
    logic [7:0] c;
    logic [7:0] d;
    int         sel;
    int         cut;
    sel = $urandom_range(0, 99);
    if (longest) len = 8'hFF;
    else if (sel < 70) len = 8'($urandom_range(0, 6));
    else if (sel < 96) len = 8'($urandom_range(7, 24));
    else len = 8'($urandom_range(25, 120));
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len) : -1;

    // noise between frames
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end

    put_decoded(START_BYTE);
    put_decoded(len);
    c = deframer_model::crc_step(CRC_PRESET, len);
    for (int i = 0; i < len; i++) begin
      if (i == cut) return;
      d = pick_payload();
      put_decoded(d);
      c = deframer_model::crc_step(c, d);
    end
    if (cut == int'(len)) return;
    if ($urandom_range(0, 6) == 0) c = c ^ 8'($urandom_range(1, 255));
    put_decoded(c);
  endfunction

  // directed frames first, then random traffic
  function void build_stimulus();
    logic [7:0] c;
    logic [7:0] body_c[5];
    int         target;
    int         nframes;

    // bytes while hunting, including escape after escape and unknown escape
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(ESC_CODE_AA);
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(8'h33);

    // escaped start value, zero length, good crc
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(ESC_CODE_55);
    line_bytes.push_back(8'h00);
    put_decoded(deframer_model::crc_step(CRC_PRESET, 8'h00));

    // extreme payload values, bad crc
    line_bytes.push_back(START_BYTE);
    line_bytes.push_back(8'h02);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h00);
    c = deframer_model::crc_step(CRC_PRESET, 8'h02);
    c = deframer_model::crc_step(c, 8'hFF);
    c = deframer_model::crc_step(c, 8'h00);
    put_decoded(c ^ 8'h01);

    // escaped escape, start value as data, unknown escape in payload
    body_c = '{8'h04, ESCAPE_BYTE, START_BYTE, 8'h33, ESC_CODE_55};
    line_bytes.push_back(START_BYTE);
    line_bytes.push_back(8'h04);
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(ESC_CODE_AA);
    line_bytes.push_back(START_BYTE);
    line_bytes.push_back(ESCAPE_BYTE);
    line_bytes.push_back(8'h33);
    line_bytes.push_back(ESC_CODE_55);
    c = CRC_PRESET;
    foreach (body_c[i]) c = deframer_model::crc_step(c, body_c[i]);
    put_decoded(c);

    target  = line_bytes.size() + RANDOM_LINE_BYTES;
    nframes = 0;
    while (line_bytes.size() < target) begin
      add_random_frame(nframes == 5);
      nframes++;
    end
  endfunction

  // one byte offered until transferred, called at a falling edge
  task send_byte(input logic [7:0] b);
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  task drive_line();
    int burst;
    int gap;
    while (line_bytes.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && line_bytes.size() > 0) begin
        send_byte(line_bytes.pop_front());
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // receiver: stall pattern in spans, plus one long hold-off
  initial begin
    int  mode;
    int  span;
    bit  held_off;
    out_if.ready = 1'b0;
    held_off     = 1'b0;
    @(negedge clk);
    forever begin
      if (!held_off && bytes_taken > 200) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      repeat (span) begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= 1'($urandom_range(0, 1));
          2: out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // transfer monitor and idle watchdog
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      model.check_result(out_if.kind, out_if.data_byte);
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      model.take_line_byte(in_if.rx_byte);
      bytes_taken++;
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // reset, stimulus, drain, verdict
  initial begin
    in_if.valid   = 1'b0;
    in_if.rx_byte = 8'h00;
    rst_n         = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drive_line();
    while (model.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/sfd_pkg.sv
src/sfd_if.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/stuffed_frame_deserializer_core.sv
dv/tb_top.sv
